FILE: sv/udsp_pkg.sv
// Shared types, codes and helpers for the unified-diff statistics parser.
package udsp_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int MAX_RESULTS         = 3;
   localparam int SLOT_IDX_WIDTH      = $clog2(MAX_RESULTS);
   localparam int SLOT_CNT_WIDTH      = $clog2(MAX_RESULTS + 1);

   // Characters that steer line classification
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      EV_FILE    = 3'd0,
      EV_HUNK    = 3'd1,
      EV_SUMMARY = 3'd2,
      EV_ERROR   = 3'd3,
      EV_END     = 3'd4
   } event_kind_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [31:0]    byte_offset;
      logic [31:0]    added_lines;
      logic [31:0]    deleted_lines;
      logic [31:0]    hunk_total;
      logic [31:0]    file_number;
      logic           last_result;
   } result_type;

   // Results caused by one byte, handed from the parser to the queue
   typedef struct packed {
      logic [SLOT_CNT_WIDTH-1:0]       count;
      result_type [MAX_RESULTS-1:0]    slot;
   } push_type;

   function automatic result_type make_result(
      input event_kind_type kind,
      input logic [31:0]    off,
      input logic [31:0]    adds,
      input logic [31:0]    dels,
      input logic [31:0]    hunks,
      input logic [31:0]    fnum
   );
      result_type r;
      r.event_kind    = kind;
      r.byte_offset   = off;
      r.added_lines   = adds;
      r.deleted_lines = dels;
      r.hunk_total    = hunks;
      r.file_number   = fnum;
      r.last_result   = 1'b0;
      return r;
   endfunction

endpackage

FILE: sv/udsp_if.sv
// Request and response channel interfaces of the diff parser.
interface udsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       is_last;

   modport source (output valid, output text_byte, output is_last, input ready);
   modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface udsp_rsp_if;
   logic                     valid;
   logic                     ready;
   udsp_pkg::event_kind_type event_kind;
   logic [31:0]              byte_offset;
   logic [31:0]              added_lines;
   logic [31:0]              deleted_lines;
   logic [31:0]              hunk_total;
   logic [31:0]              file_number;
   logic                     last_result;

   modport source (
      output valid, output event_kind, output byte_offset, output added_lines,
      output deleted_lines, output hunk_total, output file_number,
      output last_result, input ready
   );
   modport sink (
      input valid, input event_kind, input byte_offset, input added_lines,
      input deleted_lines, input hunk_total, input file_number,
      input last_result, output ready
   );
endinterface

FILE: sv/udsp_parser.sv
// Line-phase machine, offsets and saturating counters; builds the results of one byte.
module udsp_parser #(
   parameter int COUNT_WIDTH = udsp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         text_byte,
   input  logic               is_last,
   output udsp_pkg::push_type push
);

   typedef enum logic [2:0] {
      PH_START, PH_D, PH_DI, PH_DIF, PH_AT, PH_SKIP
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   phase_type              phase_ff, phase_in;
   logic [31:0]            offset_ff, offset_in;
   logic [31:0]            line_start_ff, line_start_in;
   logic                   seeking_ff, seeking_in;
   logic                   open_ff, open_in;
   logic                   error_ff, error_in;
   logic [COUNT_WIDTH-1:0] files_ff, files_in;
   logic [COUNT_WIDTH-1:0] add_ff, add_in;
   logic [COUNT_WIDTH-1:0] del_ff, del_in;
   logic [COUNT_WIDTH-1:0] hunk_ff, hunk_in;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_ONE;
   endfunction

   function automatic logic [31:0] low32(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[31:0];
   endfunction

   // Work out next state and the results of the byte on the input
   always_comb begin
      logic                             handled;
      logic                             header_now;
      logic [udsp_pkg::SLOT_CNT_WIDTH-1:0] n;
      udsp_pkg::result_type [udsp_pkg::MAX_RESULTS-1:0] slot;

      handled       = 1'b0;
      header_now    = 1'b0;
      n             = '0;
      slot          = '0;
      phase_in      = phase_ff;
      offset_in     = offset_ff + 32'd1;
      line_start_in = line_start_ff;
      seeking_in    = seeking_ff;
      open_in       = open_ff;
      error_in      = error_ff;
      files_in      = files_ff;
      add_in        = add_ff;
      del_in        = del_ff;
      hunk_in       = hunk_ff;

      if (!error_ff) begin
         // skip everything after a file header until a line opens with '@'
         if (seeking_ff) begin
            if (text_byte == udsp_pkg::CHAR_LF) begin
               phase_in = PH_START;
               handled  = 1'b1;
            end else if (phase_ff == PH_START && text_byte == udsp_pkg::CHAR_AT) begin
               seeking_in = 1'b0;
            end else begin
               phase_in = PH_SKIP;
               handled  = 1'b1;
            end
         end

         if (!handled) begin
            unique case (phase_ff)
               PH_START: begin
                  line_start_in = offset_ff;
                  if (text_byte == udsp_pkg::CHAR_LF) begin
                     phase_in = PH_START;
                  end else if (text_byte == udsp_pkg::CHAR_D) begin
                     phase_in = PH_D;
                  end else if (text_byte == udsp_pkg::CHAR_AT) begin
                     phase_in = PH_AT;
                  end else begin
                     if (open_ff && text_byte == udsp_pkg::CHAR_PLUS) begin
                        add_in = sat_inc(add_ff);
                     end else if (open_ff && text_byte == udsp_pkg::CHAR_MINUS) begin
                        del_in = sat_inc(del_ff);
                     end
                     phase_in = PH_SKIP;
                  end
               end
               PH_D, PH_DI, PH_DIF: begin
                  if (phase_ff == PH_D && text_byte == udsp_pkg::CHAR_I) begin
                     phase_in = PH_DI;
                  end else if (phase_ff == PH_DI && text_byte == udsp_pkg::CHAR_F) begin
                     phase_in = PH_DIF;
                  end else if (phase_ff == PH_DIF && text_byte == udsp_pkg::CHAR_F) begin
                     // close the previous file, open the new one
                     if (open_ff) begin
                        slot[n] = udsp_pkg::make_result(udsp_pkg::EV_SUMMARY, 32'd0,
                           low32(add_ff), low32(del_ff), low32(hunk_ff),
                           low32(files_ff - COUNT_ONE));
                        n = n + 1'b1;
                     end
                     slot[n] = udsp_pkg::make_result(udsp_pkg::EV_FILE, line_start_ff,
                        32'd0, 32'd0, 32'd0, low32(files_ff));
                     n          = n + 1'b1;
                     files_in   = sat_inc(files_ff);
                     add_in     = '0;
                     del_in     = '0;
                     hunk_in    = '0;
                     open_in    = 1'b1;
                     seeking_in = 1'b1;
                     header_now = 1'b1;
                     phase_in   = PH_SKIP;
                  end else begin
                     phase_in = (text_byte == udsp_pkg::CHAR_LF) ? PH_START : PH_SKIP;
                  end
               end
               PH_AT: begin
                  if (text_byte == udsp_pkg::CHAR_AT) begin
                     if (!open_ff) begin
                        slot[n] = udsp_pkg::make_result(udsp_pkg::EV_ERROR, 32'd0,
                           32'd0, 32'd0, 32'd0, 32'd0);
                        n        = n + 1'b1;
                        error_in = 1'b1;
                     end else begin
                        slot[n] = udsp_pkg::make_result(udsp_pkg::EV_HUNK, line_start_ff,
                           32'd0, 32'd0, 32'd0, low32(files_ff - COUNT_ONE));
                        n       = n + 1'b1;
                        hunk_in = sat_inc(hunk_ff);
                     end
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = (text_byte == udsp_pkg::CHAR_LF) ? PH_START : PH_SKIP;
                  end
               end
               default: begin
                  phase_in = (text_byte == udsp_pkg::CHAR_LF) ? PH_START : PH_SKIP;
               end
            endcase
         end
      end

      // close the text: final summary and end record unless an error was flagged, then back to reset values
      if (is_last) begin
         if (!error_in) begin
            if (open_in && !header_now) begin
               slot[n] = udsp_pkg::make_result(udsp_pkg::EV_SUMMARY, 32'd0,
                  low32(add_in), low32(del_in), low32(hunk_in),
                  low32(files_in - COUNT_ONE));
               n = n + 1'b1;
            end
            slot[n] = udsp_pkg::make_result(udsp_pkg::EV_END, 32'd0,
               32'd0, 32'd0, 32'd0, low32(files_in));
            n = n + 1'b1;
         end
         phase_in      = PH_START;
         offset_in     = '0;
         line_start_in = '0;
         seeking_in    = 1'b0;
         open_in       = 1'b0;
         error_in      = 1'b0;
         files_in      = '0;
         add_in        = '0;
         del_in        = '0;
         hunk_in       = '0;
      end

      // flag the final result of this byte
      for (int i = 0; i < udsp_pkg::MAX_RESULTS; i++) begin
         slot[i].last_result = (udsp_pkg::SLOT_CNT_WIDTH'(i + 1) == n);
      end

      push.count = n;
      push.slot  = slot;
   end

   // Hold parser state; advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         offset_ff     <= '0;
         line_start_ff <= '0;
         seeking_ff    <= 1'b0;
         open_ff       <= 1'b0;
         error_ff      <= 1'b0;
         files_ff      <= '0;
         add_ff        <= '0;
         del_ff        <= '0;
         hunk_ff       <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         line_start_ff <= line_start_in;
         seeking_ff    <= seeking_in;
         open_ff       <= open_in;
         error_ff      <= error_in;
         files_ff      <= files_in;
         add_ff        <= add_in;
         del_ff        <= del_in;
         hunk_ff       <= hunk_in;
      end
   end

endmodule

FILE: sv/udsp_rsp_queue.sv
// Result register holding up to three results of one item and sending them in order.
module udsp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  udsp_pkg::push_type   push,
   input  logic                 rsp_ready,
   output logic                 can_take,
   output logic                 rsp_valid,
   output udsp_pkg::result_type rsp_data
);

   localparam logic [udsp_pkg::SLOT_CNT_WIDTH-1:0] CNT_ONE = udsp_pkg::SLOT_CNT_WIDTH'(1);
   localparam logic [udsp_pkg::SLOT_IDX_WIDTH-1:0] IDX_ONE = udsp_pkg::SLOT_IDX_WIDTH'(1);

   udsp_pkg::result_type                 slot_ff [udsp_pkg::MAX_RESULTS];
   logic [udsp_pkg::SLOT_CNT_WIDTH-1:0]  count_ff;
   logic [udsp_pkg::SLOT_IDX_WIDTH-1:0]  rd_ff;
   logic                                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   // take a new item once at most the last result is still waiting and leaves now
   assign can_take  = (count_ff == '0) || ((count_ff == CNT_ONE) && rsp_ready);

   // Hold queue control: load on push, advance on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
      end else if (push_valid) begin
         count_ff <= push.count;
         rd_ff    <= '0;
      end else if (pop) begin
         count_ff <= count_ff - CNT_ONE;
         rd_ff    <= rd_ff + IDX_ONE;
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (push_valid) begin
         for (int i = 0; i < udsp_pkg::MAX_RESULTS; i++) begin
            slot_ff[i] <= push.slot[i];
         end
      end
   end

endmodule

FILE: sv/unified_diff_stats_parser_top.sv
// Top level of the unified-diff statistics parser.
// Takes diff text one byte per item and reports file starts, hunk headers, per-file
// summaries (additions, deletions, hunks), a hunk-without-file error and an end record.
// Each byte is classified in the cycle it is accepted and its results land in a
// three-entry result register, so bytes stream at one per cycle as long as each gives
// at most one result and rsp_ch.ready is high. A byte that gives k results (at most
// three: summary, file start, end) holds the request side while the result register
// drains, one result per cycle with rsp_ch.ready high. Counters saturate at
// 2^COUNT_WIDTH-1 and are reported as their low 32 bits; the byte offset wraps at 2^32.
module unified_diff_stats_parser_top #(
   parameter int COUNT_WIDTH = udsp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   udsp_req_if.sink    req_ch,
   udsp_rsp_if.source  rsp_ch
);

   logic                 accept;
   logic                 can_take;
   udsp_pkg::push_type   push;
   udsp_pkg::result_type rsp_data;

   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   udsp_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_ch.text_byte),
      .is_last   (req_ch.is_last),
      .push      (push)
   );

   udsp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push       (push),
      .rsp_ready  (rsp_ch.ready),
      .can_take   (can_take),
      .rsp_valid  (rsp_ch.valid),
      .rsp_data   (rsp_data)
   );

   // Drive the result channel payload
   assign rsp_ch.event_kind    = rsp_data.event_kind;
   assign rsp_ch.byte_offset   = rsp_data.byte_offset;
   assign rsp_ch.added_lines   = rsp_data.added_lines;
   assign rsp_ch.deleted_lines = rsp_data.deleted_lines;
   assign rsp_ch.hunk_total    = rsp_data.hunk_total;
   assign rsp_ch.file_number   = rsp_data.file_number;
   assign rsp_ch.last_result   = rsp_data.last_result;

endmodule

FILE: sv/udsp_checker.sv
// Port-level assertions for the diff parser and their bind to the top level.
module udsp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input udsp_pkg::event_kind_type rsp_event_kind,
   input logic                     rsp_last_result
);

   // no result is offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before taken");

   // requests wait while further results of the same item are pending
   a_req_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !req_ready)
      else $error("request taken while results pending");

   // the end record closes the results of its item
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == udsp_pkg::EV_END |-> rsp_last_result)
      else $error("end record not marked last");

   // the error record closes the results of its item
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == udsp_pkg::EV_ERROR |-> rsp_last_result)
      else $error("error record not marked last");

endmodule

bind unified_diff_stats_parser_top udsp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_event_kind  (rsp_ch.event_kind),
   .rsp_last_result (rsp_ch.last_result)
);
